[hdl/edf_pkg.sv]
// Shared types, constants and width helpers for the deadline-first arbiter.
package edf_pkg;

  // Default sizing for the top-level parameters.
  localparam int DEF_MAX_SLOTS = 8;
  localparam int DEF_TIME_BITS = 32;

  // Fixed field widths of the payload ports.
  localparam int KIND_W      = 2;
  localparam int SLOT_FLD_W  = 3;
  localparam int TIME_FLD_W  = 32;
  localparam int WCNT_FLD_W  = 4;
  localparam int SLOTS_REG_W = 4;

  // Largest value the waiting count port can show.
  localparam logic [WCNT_FLD_W-1:0] WCNT_SAT = '1;

  // Register file sizing.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Depth of the queues between front, back and result port.
  localparam int QUEUE_DEPTH = 2;

  // Reset values of the registers.
  localparam logic                   POLICY_RST = 1'b1;
  localparam logic [SLOTS_REG_W-1:0] SLOTS_RST  = 4'd8;

  // Selection policy codes.
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_EDF  = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_REQ  = 2'd0,
    KIND_REL  = 2'd1,
    KIND_TICK = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_POLICY   = 2'd0,
    REG_BURNOUT  = 2'd1,
    REG_COOLDOWN = 2'd2,
    REG_SLOTS    = 2'd3
  } reg_idx_e;

  // Classification of one item, passed from the front to the back.
  typedef struct packed {
    logic is_req;
    logic is_rel;
  } cmd_ctl_t;

  // One result transfer.
  typedef struct packed {
    logic                  grant_valid;
    logic [SLOT_FLD_W-1:0] grant_slot;
    logic [WCNT_FLD_W-1:0] waiting_count;
    logic                  resource_held;
  } res_t;

  function automatic int slot_width(input int slots);
    return (slots > 1) ? $clog2(slots) : 1;
  endfunction

  function automatic int cnt_width(input int slots);
    return $clog2(slots + 1);
  endfunction

  // Width that holds both the slot limit and the slots register.
  function automatic int lim_width(input int slots);
    return ($clog2(slots + 1) > SLOTS_REG_W) ? $clog2(slots + 1) + 1 : SLOTS_REG_W + 1;
  endfunction

endpackage

[hdl/edf_queue.sv]
// Small synchronous queue used between the arbiter stages.
module edf_queue import edf_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

[hdl/edf_front.sv]
// Front stage: takes items, classifies them and forms deadline and cooldown end.
module edf_front import edf_pkg::*; #(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS,
  parameter int TIME_BITS = DEF_TIME_BITS,
  parameter int SLOT_W    = slot_width(MAX_SLOTS),
  parameter int LIM_W     = lim_width(MAX_SLOTS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [KIND_W-1:0]     req_type_i,
  input  logic [SLOT_FLD_W-1:0] slot_index_i,
  input  logic [TIME_FLD_W-1:0] start_time_i,
  input  logic [TIME_FLD_W-1:0] now_time_i,
  input  logic [TIME_FLD_W-1:0] burnout_i,
  input  logic [TIME_FLD_W-1:0] cooldown_i,
  input  logic [LIM_W-1:0]      lim_i,
  output logic                  cmd_push_o,
  input  logic                  cmd_full_i,
  output cmd_ctl_t              cmd_ctl_o,
  output logic [SLOT_W-1:0]     cmd_slot_o,
  output logic [TIME_BITS:0]    cmd_deadline_o,
  output logic [TIME_BITS:0]    cmd_free_o,
  output logic [TIME_BITS-1:0]  cmd_now_o
);

  logic                 vld_q;
  logic                 accept;
  cmd_ctl_t             ctl_d;
  logic [TIME_BITS-1:0] start_t, now_t, burn_t, cool_t;

  assign full_o     = vld_q && cmd_full_i;
  assign accept     = push_i && !full_o;
  assign cmd_push_o = vld_q;

  assign start_t = TIME_BITS'(start_time_i);
  assign now_t   = TIME_BITS'(now_time_i);
  assign burn_t  = TIME_BITS'(burnout_i);
  assign cool_t  = TIME_BITS'(cooldown_i);

  // A request only counts when its slot lies under the active limit.
  always_comb begin
    ctl_d = '0;
    unique case (kind_e'(req_type_i))
      KIND_REQ: ctl_d.is_req = (LIM_W'(slot_index_i) < lim_i);
      KIND_REL: ctl_d.is_rel = 1'b1;
      default:  ctl_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= 1'b1;
    end else if (!cmd_full_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_ctl_o      <= ctl_d;
      cmd_slot_o     <= SLOT_W'(slot_index_i);
      cmd_deadline_o <= (TIME_BITS + 1)'(start_t) + (TIME_BITS + 1)'(burn_t);
      cmd_free_o     <= (TIME_BITS + 1)'(now_t) + (TIME_BITS + 1)'(cool_t);
      cmd_now_o      <= now_t;
    end
  end

endmodule

[hdl/edf_back.sv]
// Back stage: slot memory, state update and sequential selection scan.
module edf_back import edf_pkg::*; #(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS,
  parameter int TIME_BITS = DEF_TIME_BITS,
  parameter int SLOT_W    = slot_width(MAX_SLOTS),
  parameter int LIM_W     = lim_width(MAX_SLOTS)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 policy_i,
  input  logic [LIM_W-1:0]     lim_i,
  input  logic                 cmd_vld_i,
  output logic                 cmd_pop_o,
  input  cmd_ctl_t             cmd_ctl_i,
  input  logic [SLOT_W-1:0]    cmd_slot_i,
  input  logic [TIME_BITS:0]   cmd_deadline_i,
  input  logic [TIME_BITS:0]   cmd_free_i,
  input  logic [TIME_BITS-1:0] cmd_now_i,
  input  logic                 res_full_i,
  output logic                 res_push_o,
  output res_t                 res_o
);

  localparam int CNT_W = cnt_width(MAX_SLOTS);
  localparam int OCW   = (CNT_W > WCNT_FLD_W) ? CNT_W : WCNT_FLD_W;
  localparam int ENT_W = 2 * TIME_BITS + 1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_APPLY = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_LAST  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Each entry holds {deadline, arrival}.
  logic [ENT_W-1:0]     mem_q [MAX_SLOTS];
  logic [ENT_W-1:0]     rd_q;
  logic [MAX_SLOTS-1:0] wait_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 held_q;
  logic [TIME_BITS:0]   free_q;
  logic                 elig_q;

  cmd_ctl_t             ctl_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [TIME_BITS:0]   deadline_q;
  logic [TIME_BITS:0]   cfree_q;
  logic [TIME_BITS-1:0] now_q;

  logic [SLOT_W-1:0]    scan_q;
  logic [SLOT_W-1:0]    pidx_q;
  logic                 pv_q;
  logic                 found_q;
  logic [SLOT_W-1:0]    best_idx_q;
  logic [TIME_BITS:0]   best_key_q;

  logic                 held_nxt, elig_nxt, scan_last, grant;
  logic [TIME_BITS:0]   free_nxt, key;
  logic [CNT_W-1:0]     cnt_after;
  logic [OCW-1:0]       cnt_ext;

  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_vld_i;

  // A release only takes effect while the resource is held.
  assign held_nxt = held_q && !ctl_q.is_rel;
  assign free_nxt = (ctl_q.is_rel && held_q) ? cfree_q : free_q;
  assign elig_nxt = !held_nxt && ((TIME_BITS + 1)'(now_q) >= free_nxt);

  assign scan_last = (scan_q == SLOT_W'(MAX_SLOTS - 1));
  assign key = (policy_i == POLICY_EDF) ? rd_q[ENT_W-1:TIME_BITS]
                                        : {1'b0, rd_q[TIME_BITS-1:0]};

  assign grant      = elig_q && found_q;
  assign res_push_o = (state_q == ST_DONE) && !res_full_i;
  assign cnt_after  = grant ? cnt_q - 1'b1 : cnt_q;
  assign cnt_ext    = OCW'(cnt_after);

  always_comb begin
    res_o.grant_valid   = grant;
    res_o.grant_slot    = grant ? SLOT_FLD_W'(best_idx_q) : '0;
    res_o.waiting_count = (cnt_ext > OCW'(WCNT_SAT)) ? WCNT_SAT : WCNT_FLD_W'(cnt_ext);
    res_o.resource_held = held_q || grant;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (cmd_vld_i) state_d = ST_APPLY;
      ST_APPLY: state_d = elig_nxt ? ST_SCAN : ST_DONE;
      ST_SCAN:  if (scan_last) state_d = ST_LAST;
      ST_LAST:  state_d = ST_DONE;
      ST_DONE:  if (!res_full_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wait_q  <= '0;
      cnt_q   <= '0;
      held_q  <= 1'b0;
      free_q  <= '0;
      elig_q  <= 1'b0;
      scan_q  <= '0;
      pv_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pv_q    <= (state_q == ST_SCAN) && wait_q[scan_q] && (LIM_W'(scan_q) < lim_i);
      if (state_q == ST_APPLY) begin
        held_q  <= held_nxt;
        free_q  <= free_nxt;
        elig_q  <= elig_nxt;
        found_q <= 1'b0;
        scan_q  <= '0;
        if (ctl_q.is_req && !wait_q[slot_q]) begin
          wait_q[slot_q] <= 1'b1;
          cnt_q          <= cnt_q + 1'b1;
        end
      end
      if (state_q == ST_SCAN && !scan_last) begin
        scan_q <= scan_q + 1'b1;
      end
      // Strict compare in ascending slot order keeps ties on the lowest slot.
      if (pv_q && (!found_q || key < best_key_q)) begin
        found_q <= 1'b1;
      end
      if (res_push_o && grant) begin
        wait_q[best_idx_q] <= 1'b0;
        cnt_q              <= cnt_after;
        held_q             <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      ctl_q      <= cmd_ctl_i;
      slot_q     <= cmd_slot_i;
      deadline_q <= cmd_deadline_i;
      cfree_q    <= cmd_free_i;
      now_q      <= cmd_now_i;
    end
    if (state_q == ST_APPLY && ctl_q.is_req) begin
      mem_q[slot_q] <= {deadline_q, now_q};
    end
    rd_q   <= mem_q[scan_q];
    pidx_q <= scan_q;
    if (pv_q && (!found_q || key < best_key_q)) begin
      best_key_q <= key;
      best_idx_q <= pidx_q;
    end
  end

endmodule

[hdl/edf_fifo_resource_arbiter_top.sv]
// Top level of the deadline-first or FIFO resource arbiter with register port.
//
//  Channel   | Direction | Handshake              | Payload
//  ----------+-----------+------------------------+-----------------------------------------
//  items     | in        | push / full            | req_type, slot_index, start_time, now_time
//  results   | out       | pop / empty            | grant_valid, grant_slot, waiting_count,
//            |           |                        | resource_held
//  registers | in/out    | psel, penable, pready  | paddr, pwrite, pwdata, prdata
//
// A transfer on the item side is registered by the front stage and lands in a
// two-entry command queue; the back stage takes one command at a time. A command
// that allows no grant goes from the apply state straight to done; one that can
// be granted first scans the slots, one per cycle through the single read port of
// the slot memory, and then a last state. Reset is asynchronous and active low; it
// clears all waiting marks, the hold flag and the cooldown end, so no memory
// sweep is needed. Either side may stall: the command queue and the result queue
// let the front keep taking items while a finished result waits to be popped.
module edf_fifo_resource_arbiter_top import edf_pkg::*; #(
  parameter int MAX_SLOTS = DEF_MAX_SLOTS,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Item side.
  input  logic                  push,
  output logic                  full,
  input  logic [KIND_W-1:0]     req_type_i,
  input  logic [SLOT_FLD_W-1:0] slot_index_i,
  input  logic [TIME_FLD_W-1:0] start_time_i,
  input  logic [TIME_FLD_W-1:0] now_time_i,
  // Result side.
  output logic                  empty,
  input  logic                  pop,
  output logic                  grant_valid_o,
  output logic [SLOT_FLD_W-1:0] grant_slot_o,
  output logic [WCNT_FLD_W-1:0] waiting_count_o,
  output logic                  resource_held_o,
  // Register port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int SLOT_W = slot_width(MAX_SLOTS);
  localparam int LIM_W  = lim_width(MAX_SLOTS);
  localparam int CMD_W  = $bits(cmd_ctl_t) + SLOT_W + 3 * TIME_BITS + 2;
  localparam int RES_W  = $bits(res_t);

  // Configuration registers.
  logic                   policy_q;
  logic [TIME_FLD_W-1:0]  burnout_q;
  logic [TIME_FLD_W-1:0]  cooldown_q;
  logic [SLOTS_REG_W-1:0] slots_q;
  logic [LIM_W-1:0]       lim;
  logic                   reg_wr;
  reg_idx_e               reg_idx;

  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q   <= POLICY_RST;
      burnout_q  <= '0;
      cooldown_q <= '0;
      slots_q    <= SLOTS_RST;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_POLICY:   policy_q   <= pwdata[0];
        REG_BURNOUT:  burnout_q  <= pwdata;
        REG_COOLDOWN: cooldown_q <= pwdata;
        REG_SLOTS:    slots_q    <= pwdata[SLOTS_REG_W-1:0];
        default:      policy_q   <= policy_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_POLICY:   prdata = APB_DATA_W'(policy_q);
      REG_BURNOUT:  prdata = burnout_q;
      REG_COOLDOWN: prdata = cooldown_q;
      REG_SLOTS:    prdata = APB_DATA_W'(slots_q);
      default:      prdata = '0;
    endcase
  end

  // Slots above the configured count, or beyond the storage, never take part.
  assign lim = (LIM_W'(slots_q) > LIM_W'(MAX_SLOTS)) ? LIM_W'(MAX_SLOTS) : LIM_W'(slots_q);

  // Front stage and command queue.
  logic                 fr_push, cq_full, cq_empty, cq_pop;
  cmd_ctl_t             fr_ctl, bk_ctl;
  logic [SLOT_W-1:0]    fr_slot, bk_slot;
  logic [TIME_BITS:0]   fr_deadline, bk_deadline, fr_free, bk_free;
  logic [TIME_BITS-1:0] fr_now, bk_now;
  logic [CMD_W-1:0]     cq_wdata, cq_rdata;

  edf_front #(
    .MAX_SLOTS(MAX_SLOTS),
    .TIME_BITS(TIME_BITS),
    .SLOT_W   (SLOT_W),
    .LIM_W    (LIM_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .req_type_i    (req_type_i),
    .slot_index_i  (slot_index_i),
    .start_time_i  (start_time_i),
    .now_time_i    (now_time_i),
    .burnout_i     (burnout_q),
    .cooldown_i    (cooldown_q),
    .lim_i         (lim),
    .cmd_push_o    (fr_push),
    .cmd_full_i    (cq_full),
    .cmd_ctl_o     (fr_ctl),
    .cmd_slot_o    (fr_slot),
    .cmd_deadline_o(fr_deadline),
    .cmd_free_o    (fr_free),
    .cmd_now_o     (fr_now)
  );

  assign cq_wdata = {fr_ctl, fr_slot, fr_deadline, fr_free, fr_now};
  assign {bk_ctl, bk_slot, bk_deadline, bk_free, bk_now} = cq_rdata;

  edf_queue #(
    .WIDTH(CMD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fr_push),
    .wdata_i(cq_wdata),
    .full_o (cq_full),
    .pop_i  (cq_pop),
    .rdata_o(cq_rdata),
    .empty_o(cq_empty)
  );

  // Back stage and result queue.
  logic             rq_full, bk_push;
  res_t             bk_res, out_res;
  logic [RES_W-1:0] rq_rdata;

  edf_back #(
    .MAX_SLOTS(MAX_SLOTS),
    .TIME_BITS(TIME_BITS),
    .SLOT_W   (SLOT_W),
    .LIM_W    (LIM_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .policy_i      (policy_q),
    .lim_i         (lim),
    .cmd_vld_i     (!cq_empty),
    .cmd_pop_o     (cq_pop),
    .cmd_ctl_i     (bk_ctl),
    .cmd_slot_i    (bk_slot),
    .cmd_deadline_i(bk_deadline),
    .cmd_free_i    (bk_free),
    .cmd_now_i     (bk_now),
    .res_full_i    (rq_full),
    .res_push_o    (bk_push),
    .res_o         (bk_res)
  );

  edf_queue #(
    .WIDTH(RES_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (bk_push),
    .wdata_i(bk_res),
    .full_o (rq_full),
    .pop_i  (pop),
    .rdata_o(rq_rdata),
    .empty_o(empty)
  );

  assign out_res         = res_t'(rq_rdata);
  assign grant_valid_o   = out_res.grant_valid;
  assign grant_slot_o    = out_res.grant_slot;
  assign waiting_count_o = out_res.waiting_count;
  assign resource_held_o = out_res.resource_held;

  // A result without a grant reports slot zero.
  a_no_grant_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !grant_valid_o |-> grant_slot_o == '0)
    else $error("result without grant carries a nonzero slot");

  // A grant always leaves the resource held.
  a_grant_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && grant_valid_o |-> resource_held_o)
    else $error("grant reported while resource is free");

  // Only slots that have storage can be granted.
  a_grant_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && grant_valid_o |-> int'(grant_slot_o) < MAX_SLOTS)
    else $error("granted slot beyond the slot storage");

endmodule
